### hw/rtl/lagrange_interpolation_eval_defines.svh
`ifndef LAGRANGE_INTERPOLATION_EVAL_DEFINES_SVH
`define LAGRANGE_INTERPOLATION_EVAL_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LIE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define LIE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/lie_pkg.sv
`timescale 1ns / 1ps
package lie_pkg;

  localparam int MAX_POINTS_DEF = 16;
  localparam int DIV_STEPS      = 49;
  localparam int MUL_STEPS      = 3;
  localparam int ACC_W          = 53;
  localparam logic [46:0] MID_LIM = 47'h7FFF_FFFF_FFFF;
  localparam logic [46:0] FX_ONE  = 47'd65536;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_DUP = 2'd1,
    ST_SAT = 2'd2
  } status_t;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_EVAL = 1'b1
  } kind_t;

  typedef struct packed {
    logic               kind;
    logic [3:0]         point_index;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         status;
  } out_item_t;

  typedef enum logic {
    SRC_BASIS_FACTOR = 1'b0,
    SRC_Y_BASIS      = 1'b1
  } mul_src_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DUP_I, S_DUP_LI, S_DUP_CMP, S_DUP_J, S_DUP_ERR,
    S_EV_I, S_EV_LI, S_EV_J, S_EV_LJ, S_DIV, S_MUL_ST, S_MUL,
    S_FIN, S_FMUL, S_OUT
  } state_t;

  typedef struct packed {
    logic     wr;
    logic     eval_start;
    logic     lat_i;
    logic     init_basis;
    logic     div_start;
    logic     mul_start;
    mul_src_t mul_src;
    logic     basis_load;
    logic     acc_add;
    logic     out_load;
    logic     out_dup;
  } cmd_t;

  typedef struct packed {
    logic x_eq;
    logic div_busy;
    logic mul_busy;
    logic out_free;
  } sts_t;

endpackage

### hw/rtl/lie_ctrl.sv
`timescale 1ns / 1ps
`include "lagrange_interpolation_eval_defines.svh"
module lie_ctrl #(
  parameter int MAX_POINTS = lie_pkg::MAX_POINTS_DEF,
  parameter int AW = $clog2(MAX_POINTS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_kind,
  output logic              in_ready,
  input  logic              cfg_we,
  input  logic [4:0]        cfg_wdata,
  input  lie_pkg::sts_t     sts,
  output lie_pkg::cmd_t     cmd,
  output logic [AW-1:0]     rd_addr
);
  import lie_pkg::*;

  localparam int CW = $clog2(MAX_POINTS + 1);

  state_t        state_r, state_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt, n_eff;
  logic [4:0]    pc_r;
  logic          eval_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= 5'd1;
    end else if (cfg_we) begin
      pc_r <= cfg_wdata;
    end
  end

  // Clamp the count into 1..MAX_POINTS.
  always_comb begin
    if (pc_r == 5'd0) begin
      n_eff = CW'(1);
    end else if (32'(pc_r) > MAX_POINTS) begin
      n_eff = CW'(MAX_POINTS);
    end else begin
      n_eff = CW'(pc_r);
    end
  end

  assign eval_acc = (state_r == S_IDLE) && in_valid && (in_kind == KIND_EVAL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      i_r     <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    case (state_r)
      S_IDLE: begin
        if (eval_acc) begin
          i_nxt = '0;
          j_nxt = CW'(1);
          state_nxt = (n_eff == CW'(1)) ? S_EV_I : S_DUP_I;
        end
      end
      S_DUP_I:  state_nxt = S_DUP_LI;
      S_DUP_LI: state_nxt = S_DUP_CMP;
      S_DUP_J:  state_nxt = S_DUP_CMP;
      S_DUP_CMP: begin
        if (sts.x_eq) begin
          state_nxt = S_DUP_ERR;
        end else if ({1'b0, j_r} + 1'b1 < {1'b0, n_eff}) begin
          j_nxt = j_r + 1'b1;
          state_nxt = S_DUP_J;
        end else if ({1'b0, i_r} + 2'd2 < {1'b0, n_eff}) begin
          i_nxt = i_r + 1'b1;
          j_nxt = i_r + CW'(2);
          state_nxt = S_DUP_I;
        end else begin
          i_nxt = '0;
          state_nxt = S_EV_I;
        end
      end
      S_DUP_ERR: if (sts.out_free) state_nxt = S_IDLE;
      S_EV_I: begin
        j_nxt = '0;
        state_nxt = S_EV_LI;
      end
      S_EV_LI: state_nxt = S_EV_J;
      S_EV_J: begin
        if (j_r >= n_eff) begin
          state_nxt = S_FIN;
        end else if (j_r == i_r) begin
          j_nxt = j_r + 1'b1;
        end else begin
          state_nxt = S_EV_LJ;
        end
      end
      S_EV_LJ:  state_nxt = S_DIV;
      S_DIV:    if (!sts.div_busy) state_nxt = S_MUL_ST;
      S_MUL_ST: state_nxt = S_MUL;
      S_MUL: begin
        if (!sts.mul_busy) begin
          j_nxt = j_r + 1'b1;
          state_nxt = S_EV_J;
        end
      end
      S_FIN: state_nxt = S_FMUL;
      S_FMUL: begin
        if (!sts.mul_busy) begin
          if ({1'b0, i_r} + 1'b1 < {1'b0, n_eff}) begin
            i_nxt = i_r + 1'b1;
            state_nxt = S_EV_I;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_OUT: if (sts.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    rd_addr  = i_r[AW-1:0];
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready       = 1'b1;
        cmd.wr         = in_valid && (in_kind == KIND_LOAD);
        cmd.eval_start = eval_acc;
      end
      S_DUP_I: rd_addr = i_r[AW-1:0];
      S_DUP_LI: begin
        rd_addr   = j_r[AW-1:0];
        cmd.lat_i = 1'b1;
      end
      S_DUP_J:   rd_addr = j_r[AW-1:0];
      S_DUP_CMP: rd_addr = j_r[AW-1:0];
      S_DUP_ERR: cmd.out_dup = sts.out_free;
      S_EV_I:    cmd.init_basis = 1'b1;
      S_EV_LI:   cmd.lat_i = 1'b1;
      S_EV_J:    rd_addr = j_r[AW-1:0];
      S_EV_LJ:   cmd.div_start = 1'b1;
      S_DIV:     cmd = '0;
      S_MUL_ST: begin
        cmd.mul_start = 1'b1;
        cmd.mul_src   = SRC_BASIS_FACTOR;
      end
      S_MUL:     cmd.basis_load = !sts.mul_busy;
      S_FIN: begin
        cmd.mul_start = 1'b1;
        cmd.mul_src   = SRC_Y_BASIS;
      end
      S_FMUL:    cmd.acc_add = !sts.mul_busy;
      S_OUT:     cmd.out_load = sts.out_free;
      default:   cmd = '0;
    endcase
  end

  `LIE_ASSERT_NEXT(a_div_runs, cmd.div_start, sts.div_busy, "divider did not start")
  `LIE_ASSERT_NEXT(a_mul_runs, cmd.mul_start, sts.mul_busy, "multiplier did not start")
  `LIE_ASSERT_NOW(a_out_free, cmd.out_load || cmd.out_dup, sts.out_free, "result overwritten")
  `LIE_ASSERT_NEXT(a_eval_leaves_idle, eval_acc, state_r != S_IDLE, "evaluation not started")

endmodule

### hw/rtl/lie_dp.sv
`timescale 1ns / 1ps
module lie_dp #(
  parameter int MAX_POINTS = lie_pkg::MAX_POINTS_DEF,
  parameter int AW = $clog2(MAX_POINTS)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lie_pkg::in_item_t   in_data,
  input  lie_pkg::cmd_t       cmd,
  input  logic [AW-1:0]       rd_addr,
  output lie_pkg::sts_t       sts,
  output logic                out_valid,
  input  logic                out_ready,
  output lie_pkg::out_item_t  out_data
);
  import lie_pkg::*;

  logic [63:0]        mem [MAX_POINTS];
  logic [63:0]        rd_q_r;
  logic signed [31:0] rd_x, rd_y, x_eval_r, xi_r, yi_r;
  logic signed [32:0] num, den;
  logic [32:0]        md_r;
  logic [33:0]        rem_r, rem_t;
  logic [48:0]        dvd_r;
  logic [5:0]         dcnt_r;
  logic               div_busy_r, div_neg_r, div_sat;
  logic [46:0]        factor_mag;
  logic [47:0]        ma_r, mb_r;
  logic [95:0]        prod_r;
  logic [63:0]        pp;
  logic [1:0]         mk_r;
  logic               mul_busy_r, mul_neg_r, mul_sat;
  logic [46:0]        mul_mag;
  logic [46:0]        basis_mag_r;
  logic               basis_neg_r, sat_r;
  logic signed [ACC_W-1:0] acc_r, term;
  logic [32:0]        y_mag;
  logic               out_valid_r;
  out_item_t          out_data_r;

  assign rd_x = rd_q_r[63:32];
  assign rd_y = rd_q_r[31:0];

  // Node store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.wr && (32'(in_data.point_index) < MAX_POINTS)) begin
      mem[AW'(in_data.point_index)] <= {in_data.x_value, in_data.y_value};
    end
    rd_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.eval_start) x_eval_r <= in_data.x_value;
    if (cmd.lat_i) begin
      xi_r <= rd_x;
      yi_r <= rd_y;
    end
  end

  // Restoring divider, one quotient bit per cycle.
  assign num   = 33'(x_eval_r) - 33'(rd_x);
  assign den   = 33'(xi_r) - 33'(rd_x);
  assign rem_t = {rem_r[32:0], dvd_r[48]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
    end else if (cmd.div_start) begin
      div_busy_r <= 1'b1;
    end else if (div_busy_r && dcnt_r == 6'(DIV_STEPS - 1)) begin
      div_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dvd_r     <= {(num[32] ? 33'(-num) : 33'(num)), 16'd0};
      md_r      <= den[32] ? 33'(-den) : 33'(den);
      div_neg_r <= num[32] ^ den[32];
      rem_r     <= '0;
      dcnt_r    <= '0;
    end else if (div_busy_r) begin
      dcnt_r <= dcnt_r + 1'b1;
      if (rem_t >= {1'b0, md_r}) begin
        rem_r <= rem_t - {1'b0, md_r};
        dvd_r <= {dvd_r[47:0], 1'b1};
      end else begin
        rem_r <= rem_t;
        dvd_r <= {dvd_r[47:0], 1'b0};
      end
    end
  end

  assign div_sat    = dvd_r[48] | dvd_r[47];
  assign factor_mag = div_sat ? MID_LIM : dvd_r[46:0];
  assign y_mag      = yi_r[31] ? 33'(-33'(yi_r)) : 33'(yi_r);

  // Multiplier: 48 x 16 partial product per cycle.
  assign pp = ma_r * mb_r[16*mk_r +: 16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_busy_r <= 1'b0;
    end else if (cmd.mul_start) begin
      mul_busy_r <= 1'b1;
    end else if (mul_busy_r && mk_r == 2'(MUL_STEPS - 1)) begin
      mul_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      prod_r <= '0;
      mk_r   <= '0;
      if (cmd.mul_src == SRC_BASIS_FACTOR) begin
        ma_r      <= {1'b0, basis_mag_r};
        mb_r      <= {1'b0, factor_mag};
        mul_neg_r <= basis_neg_r ^ div_neg_r;
      end else begin
        ma_r      <= 48'(y_mag);
        mb_r      <= {1'b0, basis_mag_r};
        mul_neg_r <= yi_r[31] ^ basis_neg_r;
      end
    end else if (mul_busy_r) begin
      prod_r <= prod_r + ({32'd0, pp} << (16 * mk_r));
      mk_r   <= mk_r + 1'b1;
    end
  end

  assign mul_sat = |prod_r[95:63];
  assign mul_mag = mul_sat ? MID_LIM : prod_r[62:16];
  assign term    = mul_neg_r ? -ACC_W'(mul_mag) : ACC_W'(mul_mag);

  always_ff @(posedge clk) begin
    if (cmd.init_basis) begin
      basis_mag_r <= FX_ONE;
      basis_neg_r <= 1'b0;
    end else if (cmd.basis_load) begin
      basis_mag_r <= mul_mag;
      basis_neg_r <= mul_neg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval_start) begin
      acc_r <= '0;
      sat_r <= 1'b0;
    end else begin
      if (cmd.mul_start && cmd.mul_src == SRC_BASIS_FACTOR && div_sat) sat_r <= 1'b1;
      if (cmd.basis_load && mul_sat) sat_r <= 1'b1;
      if (cmd.acc_add) begin
        acc_r <= acc_r + term;
        if (mul_sat) sat_r <= 1'b1;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load || cmd.out_dup) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_dup) begin
      out_data_r.result_value <= '0;
      out_data_r.status       <= ST_DUP;
    end else if (cmd.out_load) begin
      if (acc_r > ACC_W'(32'sh7FFF_FFFF)) begin
        out_data_r.result_value <= 32'sh7FFF_FFFF;
        out_data_r.status       <= ST_SAT;
      end else if (acc_r < -ACC_W'(64'sh8000_0000)) begin
        out_data_r.result_value <= 32'sh8000_0000;
        out_data_r.status       <= ST_SAT;
      end else begin
        out_data_r.result_value <= acc_r[31:0];
        out_data_r.status       <= sat_r ? ST_SAT : ST_OK;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;
  assign sts.x_eq     = (rd_x == xi_r);
  assign sts.div_busy = div_busy_r;
  assign sts.mul_busy = mul_busy_r;
  assign sts.out_free = !out_valid_r || out_ready;

endmodule

### hw/rtl/lagrange_interpolation_eval.sv
// Evaluation: the sequencer runs the 49-step bit-serial divider and the 3-step multiplier
//   once per ordered node pair, and the multiplier once more per node.
// Throughput: one evaluation at a time; loads are taken every cycle while idle.
// Reset (rst_n, synchronous, active low): point_count returns to 1, control idles,
//   output empties; the node store is not cleared.
`timescale 1ns / 1ps
module lagrange_interpolation_eval #(
  parameter int MAX_POINTS = lie_pkg::MAX_POINTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lie_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output lie_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_wdata
);
  import lie_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);

  // Command and status between sequencer and datapath.
  cmd_t          cmd;
  sts_t          sts;
  logic [AW-1:0] rd_addr;

  // Sequencer: duplicate scan over node pairs, then per-node basis products
  // and accumulation; holds the point count register.
  lie_ctrl #(
    .MAX_POINTS(MAX_POINTS),
    .AW(AW)
  ) u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_kind(in_data.kind),
    .in_ready(in_ready),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .sts(sts),
    .cmd(cmd),
    .rd_addr(rd_addr)
  );

  // Datapath: node store, divider, multiplier, accumulator, result register.
  // The result register lets a new load transaction in while a result waits.
  lie_dp #(
    .MAX_POINTS(MAX_POINTS),
    .AW(AW)
  ) u_dp (
    .clk(clk),
    .rst_n(rst_n),
    .in_data(in_data),
    .cmd(cmd),
    .rd_addr(rd_addr),
    .sts(sts),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

endmodule
